FILE: rtl/core/set_pkg.sv
// ----------------------------------------------------------------------------
// set_pkg
// Shared types and codes for the sorted extent table.
// ----------------------------------------------------------------------------
package set_pkg;

	localparam int unsigned DEPTH_DEF = 32;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DUMP   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [2:0] KIND_INSERTED = 3'd0;
	localparam logic [2:0] KIND_ZERO     = 3'd1;
	localparam logic [2:0] KIND_DUP      = 3'd2;
	localparam logic [2:0] KIND_FULL     = 3'd3;
	localparam logic [2:0] KIND_EXTENT   = 3'd4;
	localparam logic [2:0] KIND_GAP      = 3'd5;
	localparam logic [2:0] KIND_EMPTY    = 3'd6;

	// one stored extent
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] count;
		logic [31:0] owner;
		logic [15:0] number;
		logic [15:0] total;
		logic        fork_f;
	} entry_t;

	// one result word
	typedef struct packed {
		logic [2:0]  kind;
		entry_t      ent;
		logic        last;
	} result_t;

endpackage

FILE: rtl/core/sorted_extent_table_top.sv
// ----------------------------------------------------------------------------
// sorted_extent_table_top
// Extent table kept sorted by start block, with ordered dump and gap records.
// ----------------------------------------------------------------------------
// An insert into a table with n stored entries (n at least one) compares them
// one at a time in a search and a compare state, then shifts the larger ones
// up one at a time in a shift and a write state; a duplicate ends the search
// at the entry that matches, and an insert into a full table ends once every
// entry has been compared. An insert into an empty table, zero-count, clear,
// unused-action and empty-table words finish straight from the idle state. A
// dump reads and emits each extent in a read and an emit state, with one more
// emit for each gap record. Every result passes a two-word output buffer, the
// input stays stalled until the last result of a word has entered it, and
// output stalls hold the emitting steps. One word is worked at a time.
module sorted_extent_table_top #(
	parameter int unsigned DEPTH = set_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] start_block,
	input  logic [31:0] blk_count,
	input  logic [31:0] file_id,
	input  logic [15:0] extent_number,
	input  logic [15:0] extent_total,
	input  logic        fork_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [31:0] out_start,
	output logic [31:0] out_count,
	output logic [31:0] out_file_id,
	output logic [15:0] out_extent_number,
	output logic [15:0] out_extent_total,
	output logic        out_fork,
	output logic        last
);

	set_pkg::entry_t  in_ent;
	set_pkg::result_t res_data, out_data;
	logic             res_valid, res_stall;

	// pack the input word
	assign in_ent = '{start: start_block, count: blk_count, owner: file_id,
	                  number: extent_number, total: extent_total, fork_f: fork_req};

	set_seq #(.DEPTH(DEPTH)) u_seq (
		.clk, .arst_n, .in_valid, .in_stall, .action, .in_ent,
		.res_valid, .res_stall, .res_data
	);

	set_outreg u_out (
		.clk, .arst_n, .in_valid(res_valid), .in_data(res_data), .in_stall(res_stall),
		.out_valid, .out_stall, .out_data
	);

	// unpack the result word
	assign kind              = out_data.kind;
	assign out_start         = out_data.ent.start;
	assign out_count         = out_data.ent.count;
	assign out_file_id       = out_data.ent.owner;
	assign out_extent_number = out_data.ent.number;
	assign out_extent_total  = out_data.ent.total;
	assign out_fork          = out_data.ent.fork_f;
	assign last              = out_data.last;

endmodule

FILE: rtl/core/set_outreg.sv
// ----------------------------------------------------------------------------
// set_outreg
// Two-entry skid buffer between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module set_outreg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  set_pkg::result_t in_data,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output set_pkg::result_t out_data
);

	set_pkg::result_t mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/core/set_seq.sv
// ----------------------------------------------------------------------------
// set_seq
// Table memory and the sequencer that searches, shifts and dumps it.
// ----------------------------------------------------------------------------
module set_seq #(
	parameter int unsigned DEPTH = set_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       action,
	input  set_pkg::entry_t  in_ent,
	output logic             res_valid,
	input  logic             res_stall,
	output set_pkg::result_t res_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SRCH  = 7'b0000010,
		ST_SCMP  = 7'b0000100,
		ST_SHIFT = 7'b0001000,
		ST_SWR   = 7'b0010000,
		ST_DUMP  = 7'b0100000,
		ST_DEMIT = 7'b1000000
	} state_t;

	set_pkg::entry_t mem [DEPTH];
	set_pkg::entry_t rd_q, new_q, prev_q;
	state_t          state_q;
	logic [CW-1:0]   fill_q, idx_q, pos_q;
	logic            has_prev_q, gap_pend_q;
	logic [AW-1:0]   rd_addr;
	logic            rd_en, wr_en;
	logic [AW-1:0]   wr_addr;
	set_pkg::entry_t wr_data;
	logic [32:0]     prev_end;
	logic            accept;
	logic [2:0]      idle_kind;
	set_pkg::entry_t gap_ent;

	assign in_stall = (state_q != ST_IDLE) || res_valid;
	assign accept   = in_valid && !in_stall;

	// synchronous table memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	assign prev_end = {1'b0, prev_q.start} + {1'b0, prev_q.count};

	// result kind for words that finish at once
	always_comb begin
		if (action == set_pkg::ACT_DUMP) idle_kind = set_pkg::KIND_EMPTY;
		else if (in_ent.count == 32'd0) idle_kind = set_pkg::KIND_ZERO;
		else idle_kind = set_pkg::KIND_INSERTED;
	end

	// free gap between the previous extent and the one just read
	always_comb begin
		gap_ent       = '0;
		gap_ent.start = prev_end[31:0];
		gap_ent.count = rd_q.start - prev_end[31:0];
	end

	// read and write control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_q;
		case (state_q)
			ST_SRCH: rd_en = (idx_q < fill_q);
			ST_SHIFT: begin
				rd_en   = 1'b1;
				rd_addr = AW'(idx_q - 1'b1);
			end
			ST_SWR: wr_en = 1'b1;
			ST_DUMP: rd_en = (idx_q < fill_q);
			ST_IDLE: begin
				if (accept && action == set_pkg::ACT_INSERT &&
				    in_ent.count != 32'd0 && fill_q == CW'(0)) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = in_ent;
				end
			end
			default: ;
		endcase
		if (state_q == ST_SHIFT && idx_q == pos_q) begin
			rd_en   = 1'b0;
			wr_en   = 1'b1;
			wr_data = new_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
			res_valid  <= 1'b0;
			res_data   <= '0;
			new_q      <= '0;
			prev_q     <= '0;
			has_prev_q <= 1'b0;
			gap_pend_q <= 1'b0;
		end else begin
			// the dump emitter handles its own valid
			if (res_valid && !res_stall && state_q != ST_DEMIT) res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						new_q    <= in_ent;
						idx_q    <= '0;
						pos_q    <= fill_q;
						res_data <= '{kind: idle_kind, ent: '0, last: 1'b1};
						case (action)
							set_pkg::ACT_INSERT: begin
								if (in_ent.count == 32'd0) begin
									res_valid <= 1'b1;
								end else if (fill_q == CW'(0)) begin
									fill_q    <= CW'(1);
									res_valid <= 1'b1;
								end else begin
									state_q <= ST_SRCH;
								end
							end
							set_pkg::ACT_DUMP: begin
								if (fill_q == CW'(0)) begin
									res_valid <= 1'b1;
								end else begin
									has_prev_q <= 1'b0;
									state_q    <= ST_DUMP;
								end
							end
							set_pkg::ACT_CLEAR: fill_q <= '0;
							default: ;
						endcase
					end
				end
				ST_SRCH: begin
					if (idx_q < fill_q) begin
						state_q <= ST_SCMP;
					end else if (fill_q >= CW'(DEPTH)) begin
						res_data.kind <= set_pkg::KIND_FULL;
						res_valid     <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						idx_q   <= fill_q;
						state_q <= ST_SHIFT;
					end
				end
				ST_SCMP: begin
					if (rd_q.start == new_q.start) begin
						res_data.kind <= set_pkg::KIND_DUP;
						res_valid     <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						if (new_q.start < rd_q.start && pos_q == fill_q) pos_q <= idx_q;
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SRCH;
					end
				end
				ST_SHIFT: begin
					if (idx_q == pos_q) begin
						fill_q        <= fill_q + 1'b1;
						res_data.kind <= set_pkg::KIND_INSERTED;
						res_valid     <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						state_q <= ST_SWR;
					end
				end
				ST_SWR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= ST_SHIFT;
				end
				ST_DUMP: begin
					state_q <= ST_DEMIT;
				end
				ST_DEMIT: begin
					if (!res_valid || !res_stall) begin
						res_valid <= 1'b1;
						if (has_prev_q && !gap_pend_q &&
						    prev_end < {1'b0, rd_q.start}) begin
							gap_pend_q <= 1'b1;
							res_data   <= '{kind: set_pkg::KIND_GAP, ent: gap_ent,
							                last: 1'b0};
						end else begin
							gap_pend_q <= 1'b0;
							has_prev_q <= 1'b1;
							prev_q     <= rd_q;
							res_data   <= '{kind: set_pkg::KIND_EXTENT, ent: rd_q,
							                last: (idx_q + 1'b1 == fill_q)};
							idx_q      <= idx_q + 1'b1;
							state_q    <= (idx_q + 1'b1 == fill_q) ? ST_IDLE : ST_DUMP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: verif/tb_sorted_extent_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_extent_table_top
// Checks the sorted extent table against an in-bench table model. Inserts,
// dumps and clears are driven through a queue, and every output word is
// compared in order against the predicted records.
// ----------------------------------------------------------------------------
module tb_sorted_extent_table_top;

	localparam int unsigned TBL_DEPTH = set_pkg::DEPTH_DEF;

	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] start;
		logic [31:0] count;
		logic [31:0] owner;
		logic [15:0] number;
		logic [15:0] total;
		logic        fork_f;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] start;
		logic [31:0] count;
		logic [31:0] owner;
		logic [15:0] number;
		logic [15:0] total;
		logic        fork_f;
		logic        last;
	} rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = '0;
	logic [31:0] start_block = '0;
	logic [31:0] blk_count = '0;
	logic [31:0] file_id = '0;
	logic [15:0] extent_number = '0;
	logic [15:0] extent_total = '0;
	logic fork_req = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] kind;
	logic [31:0] out_start, out_count, out_file_id;
	logic [15:0] out_extent_number, out_extent_total;
	logic out_fork, last;

	sorted_extent_table_top u_top (.*);

	// model table
	cmd_t tbl [TBL_DEPTH];
	int unsigned tbl_fill = 0;

	cmd_t pending_cmds[$];
	rec_t expected_recs[$];
	int errors = 0;
	int words_sent = 0;
	int recs_seen = 0;
	int gaps_seen = 0;
	int fulls_seen = 0;
	bit hold_sender = 1'b0;
	int long_hold = 0;

	initial forever #1 clk = ~clk;

	task automatic report(input string what, input rec_t got, input rec_t exp);
		errors++;
		$display("mismatch %s: got %h exp %h", what, got, exp);
	endtask

	function automatic rec_t mk(input logic [2:0] k);
		rec_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	// predict table records for one word
	task automatic predict_table(input cmd_t c);
		rec_t r;
		rec_t outs[$];
		int unsigned pos;
		logic [32:0] end_blk;
		bit dup;
		case (c.act)
			set_pkg::ACT_INSERT: begin
				dup = 1'b0;
				pos = tbl_fill;
				for (int i = 0; i < tbl_fill; i++) begin
					if (tbl[i].start == c.start) dup = 1'b1;
					if (c.start < tbl[i].start && pos == tbl_fill) pos = i;
				end
				if (c.count == 0) outs.push_back(mk(set_pkg::KIND_ZERO));
				else if (dup) outs.push_back(mk(set_pkg::KIND_DUP));
				else if (tbl_fill >= TBL_DEPTH) outs.push_back(mk(set_pkg::KIND_FULL));
				else begin
					for (int i = tbl_fill; i > pos; i--) tbl[i] = tbl[i-1];
					tbl[pos] = c;
					tbl_fill++;
					outs.push_back(mk(set_pkg::KIND_INSERTED));
				end
			end
			set_pkg::ACT_DUMP: begin
				if (tbl_fill == 0) outs.push_back(mk(set_pkg::KIND_EMPTY));
				for (int i = 0; i < tbl_fill; i++) begin
					r = mk(set_pkg::KIND_EXTENT);
					r.start = tbl[i].start;
					r.count = tbl[i].count;
					r.owner = tbl[i].owner;
					r.number = tbl[i].number;
					r.total = tbl[i].total;
					r.fork_f = tbl[i].fork_f;
					outs.push_back(r);
					if (i + 1 < tbl_fill) begin
						end_blk = {1'b0, tbl[i].start} + {1'b0, tbl[i].count};
						if (end_blk < {1'b0, tbl[i+1].start}) begin
							r = mk(set_pkg::KIND_GAP);
							r.start = end_blk[31:0];
							r.count = tbl[i+1].start - end_blk[31:0];
							outs.push_back(r);
						end
					end
				end
			end
			set_pkg::ACT_CLEAR: tbl_fill = 0;
			default: ;
		endcase
		if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
		foreach (outs[i]) expected_recs.push_back(outs[i]);
	endtask

	// input handshake, taken at the rising edge
	bit in_taken = 1'b0;
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predict_table(pending_cmds.pop_front());
			words_sent++;
			in_taken = 1'b1;
		end
	end

	// driver
	int in_wait = 0;
	always @(negedge clk) begin
		cmd_t c;
		if (arst_n) begin
			if (in_taken) begin
				in_taken = 1'b0;
				in_valid <= 1'b0;
				in_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			end else if (!in_valid && !hold_sender && pending_cmds.size() > 0) begin
				if (in_wait > 0) in_wait--;
				else begin
					c = pending_cmds[0];
					action <= c.act;
					start_block <= c.start;
					blk_count <= c.count;
					file_id <= c.owner;
					extent_number <= c.number;
					extent_total <= c.total;
					fork_req <= c.fork_f;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// receiver stall, with one long hold-off
	int out_wait = 0;
	always @(negedge clk) begin
		if (long_hold > 0) begin
			long_hold--;
			out_stall <= 1'b1;
		end else if (out_wait > 0) begin
			out_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (out_valid && !out_stall)
				out_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
		end
	end

	// monitor
	always @(posedge clk) begin
		rec_t got, exp;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, out_start, out_count, out_file_id, out_extent_number,
				out_extent_total, out_fork, last};
			recs_seen++;
			if (kind == set_pkg::KIND_GAP) gaps_seen++;
			if (kind == set_pkg::KIND_FULL) fulls_seen++;
			if (expected_recs.size() == 0) report("unexpected word", got, '0);
			else begin
				exp = expected_recs.pop_front();
				if (got.kind != exp.kind) report("kind", got, exp);
				if (got.start != exp.start) report("out_start", got, exp);
				if (got.count != exp.count) report("out_count", got, exp);
				if (got.owner != exp.owner) report("out_file_id", got, exp);
				if (got.number != exp.number) report("out_extent_number", got, exp);
				if (got.total != exp.total) report("out_extent_total", got, exp);
				if (got.fork_f != exp.fork_f) report("out_fork", got, exp);
				if (got.last != exp.last) report("last", got, exp);
			end
		end
	end

	function automatic cmd_t mk_cmd(input logic [1:0] a, input logic [31:0] s,
			input logic [31:0] n);
		cmd_t c;
		c.act = a;
		c.start = s;
		c.count = n;
		c.owner = $urandom;
		c.number = 16'($urandom);
		c.total = 16'($urandom);
		c.fork_f = 1'($urandom);
		return c;
	endfunction

	function automatic logic [31:0] rnd32();
		case ($urandom_range(0, 3))
			0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			1: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || expected_recs.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		cmd_t c;
		logic [31:0] base;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: empty dump, extremes, touch, overlap, dup, zero, unused action
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_DUMP, 0, 0));
		c = mk_cmd(set_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		c.owner = '1; c.number = '1; c.total = '1; c.fork_f = 1'b1;
		pending_cmds.push_back(c);
		c = mk_cmd(set_pkg::ACT_INSERT, 0, 1);
		c.owner = '0; c.number = '0; c.total = '0; c.fork_f = 1'b0;
		pending_cmds.push_back(c);
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT, 1, 9));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT, 10, 5));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT, 12, 100));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT, 500, 32'hFFFF_FFF0));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT, 10, 7));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT, 77, 0));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_UNUSED, 5, 5));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_DUMP, 0, 0));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_CLEAR, 0, 0));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_DUMP, 0, 0));
		wait_drained();

		// fill past full while the receiver holds off; then one more insert and a dump
		long_hold = 400;
		for (int i = 0; i < TBL_DEPTH + 2; i++)
			pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT,
				i * 64 + $urandom_range(0, 70), 40));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT, 1 << 30, 40));
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_DUMP, 0, 0));
		wait_drained();

		// sender holds back a queued dump, then is released
		hold_sender = 1'b1;
		pending_cmds.push_back(mk_cmd(set_pkg::ACT_DUMP, 0, 0));
		repeat (20) @(posedge clk);
		hold_sender = 1'b0;
		wait_drained();

		// random: mostly fill-and-dump runs with clustered starts
		while (words_sent < 358) begin
			pending_cmds.push_back(mk_cmd(set_pkg::ACT_CLEAR, 0, 0));
			base = rnd32();
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 9))
					0: pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT, rnd32(), rnd32()));
					1: pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT, base, 0));
					2: pending_cmds.push_back(mk_cmd(set_pkg::ACT_DUMP, 0, 0));
					3: pending_cmds.push_back(mk_cmd($urandom_range(0, 1) ?
						set_pkg::ACT_CLEAR : set_pkg::ACT_UNUSED, rnd32(), rnd32()));
					default: pending_cmds.push_back(mk_cmd(set_pkg::ACT_INSERT,
						base + $urandom_range(0, 400), $urandom_range(1, 60)));
				endcase
			end
			pending_cmds.push_back(mk_cmd(set_pkg::ACT_DUMP, 0, 0));
			while (pending_cmds.size() > 0) @(posedge clk);
		end
		wait_drained();

		$display("covered %0d words in, %0d records out (%0d gaps, %0d full)",
			words_sent, recs_seen, gaps_seen, fulls_seen);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/set_pkg.sv
rtl/core/set_outreg.sv
rtl/core/set_seq.sv
rtl/core/sorted_extent_table_top.sv
verif/tb_sorted_extent_table_top.sv
